/* src/rcb_pkg.sv */
// Shared types, register indexes and reset constants for the reconnect backoff core.
package rcb_pkg;

    localparam int TIME_BITS_DEF  = 32;
    localparam int RETRY_BITS_DEF = 8;

    localparam int BASE_W  = 16;
    localparam int MAX_W   = 32;
    localparam int SRETRY_W = 16;
    localparam int CFG_W   = 32;
    localparam int CFG_IDX_W = 2;
    localparam int DELAY_W = 32;

    localparam logic [BASE_W-1:0]   BASE_RESET   = BASE_W'(2000);
    localparam logic [MAX_W-1:0]    MAX_RESET    = MAX_W'(30000);
    localparam logic [SRETRY_W-1:0] SRETRY_RESET = SRETRY_W'(5000);

    localparam logic [CFG_IDX_W-1:0] REG_BACKOFF_BASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BACKOFF_MAX   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SUBSCRIBE_RTY = 2'd2;

    typedef enum logic [1:0] {
        CS_DISC       = 2'd0,
        CS_CONNECTING = 2'd1,
        CS_CONNECTED  = 2'd2,
        CS_FAILED     = 2'd3
    } conn_state_t;

    typedef enum logic [1:0] {
        SQ_IDLE    = 2'd0,
        SQ_EVAL    = 2'd1,
        SQ_BACKOFF = 2'd2,
        SQ_DONE    = 2'd3
    } seq_state_t;

endpackage

/* src/rcb_backoff.sv */
// Iterative capped-doubling unit: one shift and one compare per cycle.
module rcb_backoff #(
    parameter int RETRY_BITS = rcb_pkg::RETRY_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [rcb_pkg::BASE_W-1:0] base,
    input  logic [rcb_pkg::MAX_W-1:0]  max_val,
    input  logic [RETRY_BITS-1:0]     count,
    output logic                      busy,
    output logic                      done,
    output logic [rcb_pkg::DELAY_W-1:0] delay
);
    import rcb_pkg::*;

    logic                  busy_reg, busy_next;
    logic [MAX_W:0]        d_reg, d_next;
    logic [RETRY_BITS-1:0] iter_reg, iter_next;
    logic                  at_cap;

    // The working value never exceeds twice the cap or the base, so one extra bit is enough.
    assign at_cap = d_reg >= {1'b0, max_val};

    always_comb
    begin
        busy_next = busy_reg;
        d_next    = d_reg;
        iter_next = iter_reg;
        done      = 1'b0;
        delay     = '0;
        if (busy_reg)
        begin
            if (at_cap)
            begin
                done      = 1'b1;
                delay     = max_val;
                busy_next = 1'b0;
            end
            else if (iter_reg == count || d_reg == '0)
            begin
                // A zero value never grows, so it can stop at once.
                done      = 1'b1;
                delay     = d_reg[DELAY_W-1:0];
                busy_next = 1'b0;
            end
            else
            begin
                d_next    = {d_reg[MAX_W-1:0], 1'b0};
                iter_next = iter_reg + 1'b1;
            end
        end
        else if (start)
        begin
            busy_next = 1'b1;
            d_next    = (MAX_W + 1)'(base);
            iter_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg    <= d_next;
        iter_reg <= iter_next;
    end

    assign busy = busy_reg;

    a_done_capped: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> delay <= max_val)
        else $error("backoff delay above the cap");

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("backoff started while busy");

    a_runs_on: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && !done |=> busy_reg)
        else $error("backoff stopped without done");

endmodule

/* src/reconnect_fsm_exponential_backoff_core.sv */
// Reconnect state machine with capped exponential backoff, top level.
//
// One input beat is one tick: now_ms, link_up, connect_ok and subscribe_ok on
// a valid/ready channel. Each tick produces exactly one output beat with the
// connection state, retry count, attempt flags, event flags and the backoff
// delay chosen on that tick (zero when none was chosen).
// Configuration is a plain write port: cfg_we, cfg_index and cfg_wdata.
// Index 0 is the base delay, 1 the delay cap, 2 the subscribe retry interval.
// Write it only while no tick is in flight.
// A tick passes through the sequencer steps accept, evaluate and finish; with no
// delay to compute, its result is loaded into the output register at finish.
// When a delay is computed (failed connect or lost link) a backoff step runs the
// doubling unit between evaluate and finish: one shift and one compare against
// the cap per cycle.
// in_ready is high only while the sequencer is idle. The output register
// holds a finished beat until out_ready; the next tick is accepted meanwhile,
// and its result waits in the sequencer until the output register frees up.
// Reset puts the machine in the disconnected state with zero retries, no
// subscription, zero deadline and the register defaults.
module reconnect_fsm_exponential_backoff_core #(
    parameter int TIME_BITS  = rcb_pkg::TIME_BITS_DEF,
    parameter int RETRY_BITS = rcb_pkg::RETRY_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [rcb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rcb_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [TIME_BITS-1:0]          now_ms,
    input  logic                          link_up,
    input  logic                          connect_ok,
    input  logic                          subscribe_ok,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [1:0]                    conn_state,
    output logic [RETRY_BITS-1:0]         retries,
    output logic                          attempt_connect,
    output logic                          attempt_subscribe,
    output logic                          is_subscribed,
    output logic                          just_connected,
    output logic                          link_lost,
    output logic [rcb_pkg::DELAY_W-1:0]   delay_ms
);
    import rcb_pkg::*;

    localparam int SUM_W = (TIME_BITS > DELAY_W) ? TIME_BITS : DELAY_W;

    // Configuration registers.
    logic [BASE_W-1:0]   base_reg;
    logic [MAX_W-1:0]    max_reg;
    logic [SRETRY_W-1:0] sretry_reg;

    // Architectural state.
    conn_state_t          st_reg, st_next;
    logic [RETRY_BITS-1:0] retry_reg, retry_next;
    logic [TIME_BITS-1:0] deadline_reg, deadline_next;
    logic                 sub_reg, sub_next;
    logic [TIME_BITS-1:0] last_reg, last_next;

    // Sequencer and latched tick.
    seq_state_t           seq_reg, seq_next;
    logic [TIME_BITS-1:0] now_reg;
    logic                 link_reg, cok_reg, sok_reg;

    // Per-tick result flags.
    logic                 att_conn_reg, att_conn_next;
    logic                 att_sub_reg, att_sub_next;
    logic                 just_reg, just_next;
    logic                 lost_reg, lost_next;
    logic [DELAY_W-1:0]   dly_reg, dly_next;

    // Output register.
    logic                 ov_reg, ov_next;
    logic                 load_out;
    logic [1:0]           o_state_reg;
    logic [RETRY_BITS-1:0] o_retry_reg;
    logic                 o_att_conn_reg, o_att_sub_reg, o_sub_reg, o_just_reg, o_lost_reg;
    logic [DELAY_W-1:0]   o_dly_reg;

    logic                 bo_start, bo_busy, bo_done;
    logic [DELAY_W-1:0]   bo_delay;
    logic                 deadline_hit, sub_due;
    logic [SUM_W-1:0]     deadline_sum;
    logic [TIME_BITS-1:0] since_sub;

    rcb_backoff #(
        .RETRY_BITS (RETRY_BITS)
    ) u_backoff (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (bo_start),
        .base    (base_reg),
        .max_val (max_reg),
        .count   (retry_reg),
        .busy    (bo_busy),
        .done    (bo_done),
        .delay   (bo_delay)
    );

    assign deadline_hit = now_reg >= deadline_reg;
    assign since_sub    = now_reg - last_reg;
    assign sub_due      = since_sub >= TIME_BITS'(sretry_reg);
    assign deadline_sum = SUM_W'(now_reg) + SUM_W'(bo_delay);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg   <= BASE_RESET;
            max_reg    <= MAX_RESET;
            sretry_reg <= SRETRY_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_BACKOFF_BASE:  base_reg   <= cfg_wdata[BASE_W-1:0];
                REG_BACKOFF_MAX:   max_reg    <= cfg_wdata[MAX_W-1:0];
                REG_SUBSCRIBE_RTY: sretry_reg <= cfg_wdata[SRETRY_W-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        seq_next      = seq_reg;
        st_next       = st_reg;
        retry_next    = retry_reg;
        deadline_next = deadline_reg;
        sub_next      = sub_reg;
        last_next     = last_reg;
        att_conn_next = att_conn_reg;
        att_sub_next  = att_sub_reg;
        just_next     = just_reg;
        lost_next     = lost_reg;
        dly_next      = dly_reg;
        bo_start      = 1'b0;
        load_out      = 1'b0;
        in_ready      = 1'b0;

        unique case (seq_reg)
            SQ_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    seq_next = SQ_EVAL;
                end
            end
            SQ_EVAL:
            begin
                att_conn_next = 1'b0;
                att_sub_next  = 1'b0;
                just_next     = 1'b0;
                lost_next     = 1'b0;
                dly_next      = '0;
                seq_next      = SQ_DONE;
                unique case (st_reg)
                    CS_DISC:
                    begin
                        if (deadline_hit)
                        begin
                            st_next = CS_CONNECTING;
                        end
                    end
                    CS_CONNECTING:
                    begin
                        att_conn_next = 1'b1;
                        if (cok_reg)
                        begin
                            st_next       = CS_CONNECTED;
                            retry_next    = '0;
                            deadline_next = '0;
                            sub_next      = sok_reg;
                            att_sub_next  = 1'b1;
                            last_next     = now_reg;
                            just_next     = 1'b1;
                        end
                        else
                        begin
                            // The delay uses the count after this failure.
                            if (retry_reg != '1)
                            begin
                                retry_next = retry_reg + 1'b1;
                            end
                            st_next  = CS_FAILED;
                            bo_start = 1'b1;
                            seq_next = SQ_BACKOFF;
                        end
                    end
                    CS_CONNECTED:
                    begin
                        if (!link_reg)
                        begin
                            st_next   = CS_DISC;
                            sub_next  = 1'b0;
                            lost_next = 1'b1;
                            bo_start  = 1'b1;
                            seq_next  = SQ_BACKOFF;
                        end
                        else if (!sub_reg && sub_due)
                        begin
                            sub_next     = sok_reg;
                            att_sub_next = 1'b1;
                            last_next    = now_reg;
                        end
                    end
                    CS_FAILED:
                    begin
                        if (deadline_hit)
                        begin
                            st_next = CS_DISC;
                        end
                    end
                    default:
                    begin
                        st_next = CS_DISC;
                    end
                endcase
            end
            SQ_BACKOFF:
            begin
                if (bo_done)
                begin
                    dly_next      = bo_delay;
                    deadline_next = deadline_sum[TIME_BITS-1:0];
                    seq_next      = SQ_DONE;
                end
            end
            SQ_DONE:
            begin
                if (!ov_reg || out_ready)
                begin
                    load_out = 1'b1;
                    seq_next = SQ_IDLE;
                end
            end
            default:
            begin
                seq_next = SQ_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ov_next = ov_reg;
        if (load_out)
        begin
            ov_next = 1'b1;
        end
        else if (out_ready)
        begin
            ov_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg      <= SQ_IDLE;
            st_reg       <= CS_DISC;
            retry_reg    <= '0;
            deadline_reg <= '0;
            sub_reg      <= 1'b0;
            last_reg     <= '0;
            ov_reg       <= 1'b0;
        end
        else
        begin
            seq_reg      <= seq_next;
            st_reg       <= st_next;
            retry_reg    <= retry_next;
            deadline_reg <= deadline_next;
            sub_reg      <= sub_next;
            last_reg     <= last_next;
            ov_reg       <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            now_reg  <= now_ms;
            link_reg <= link_up;
            cok_reg  <= connect_ok;
            sok_reg  <= subscribe_ok;
        end
        att_conn_reg <= att_conn_next;
        att_sub_reg  <= att_sub_next;
        just_reg     <= just_next;
        lost_reg     <= lost_next;
        dly_reg      <= dly_next;
        if (load_out)
        begin
            o_state_reg    <= st_reg;
            o_retry_reg    <= retry_reg;
            o_att_conn_reg <= att_conn_reg;
            o_att_sub_reg  <= att_sub_reg;
            o_sub_reg      <= sub_reg;
            o_just_reg     <= just_reg;
            o_lost_reg     <= lost_reg;
            o_dly_reg      <= dly_reg;
        end
    end

    assign out_valid         = ov_reg;
    assign conn_state        = o_state_reg;
    assign retries           = o_retry_reg;
    assign attempt_connect   = o_att_conn_reg;
    assign attempt_subscribe = o_att_sub_reg;
    assign is_subscribed     = o_sub_reg;
    assign just_connected    = o_just_reg;
    assign link_lost         = o_lost_reg;
    assign delay_ms          = o_dly_reg;

    a_conn_no_retries: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && conn_state == CS_CONNECTED |-> retries == '0)
        else $error("connected with a nonzero retry count");

    a_lost_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && link_lost |-> conn_state == CS_DISC && !is_subscribed)
        else $error("lost link left the machine connected or subscribed");

    a_connect_outcome: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && attempt_connect |->
            conn_state == CS_CONNECTED || conn_state == CS_FAILED)
        else $error("connect attempt left an unexpected state");

    a_just_no_delay: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && just_connected |-> delay_ms == '0 && attempt_subscribe)
        else $error("successful connect with a delay or without a subscribe");

    a_backoff_only_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        bo_busy |-> seq_reg == SQ_BACKOFF)
        else $error("doubling unit busy outside its sequencer step");

endmodule
